// File: rtl/refa_pkg.sv
// Shared types, constants and helper functions for the reference number allocator.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package refa_pkg;

    localparam int REF_SLOTS = 256;
    localparam int SLOT_W    = $clog2(REF_SLOTS);
    localparam int CNT_W     = $clog2(REF_SLOTS + 1);
    localparam int ROW_BITS  = 16;
    localparam int BIT_W     = $clog2(ROW_BITS);
    localparam int ROWS      = (REF_SLOTS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic ACT_OBTAIN = 1'b0;
    localparam logic ACT_FREE   = 1'b1;

    localparam logic [1:0] STAT_ALLOC   = 2'd0;
    localparam logic [1:0] STAT_NOREF   = 2'd1;
    localparam logic [1:0] STAT_FREED   = 2'd2;
    localparam logic [1:0] STAT_WASFREE = 2'd3;

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [ROW_IDX_W-1:0] row_idx_t;
    typedef logic [BIT_W-1:0]     bit_idx_t;
    typedef logic [ROW_BITS-1:0]  row_t;
    typedef logic [ROWS-1:0]      row_vec_t;

    typedef struct packed {
        logic        action;
        logic [15:0] owner_handle;
        logic [7:0]  ref_number;
    } req_t;

    typedef struct packed {
        logic [7:0] ref_out;
        logic [1:0] status;
        logic [7:0] highest_open;
        logic [7:0] open_count;
    } rsp_t;

    typedef struct packed {
        logic     en;
        row_idx_t row;
    } bm_rd_t;

    typedef struct packed {
        logic     en;
        row_idx_t row;
        row_t     data;
    } bm_wr_t;

    typedef struct packed {
        row_vec_t nonempty;
        row_vec_t full;
    } bm_sum_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_UPD,
        ST_SCAN,
        ST_HIGH,
        ST_DONE
    } refa_state_t;

    function automatic row_t usable_mask(row_idx_t row);
        row_t m;
        int   idx;
        m = '0;
        for (int b = 0; b < ROW_BITS; b++)
        begin
            idx  = int'(row) * ROW_BITS + b;
            m[b] = (idx != 0) && (idx < REF_SLOTS);
        end
        return m;
    endfunction

    function automatic row_idx_t lowest_row(row_vec_t v);
        row_idx_t idx;
        idx = '0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (v[i])
                idx = ROW_IDX_W'(i);
        end
        return idx;
    endfunction

    function automatic row_idx_t highest_row(row_vec_t v);
        row_idx_t idx;
        idx = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            if (v[i])
                idx = ROW_IDX_W'(i);
        end
        return idx;
    endfunction

    function automatic bit_idx_t lowest_bit(row_t v);
        bit_idx_t idx;
        idx = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
                idx = BIT_W'(i);
        end
        return idx;
    endfunction

    function automatic bit_idx_t highest_bit(row_t v);
        bit_idx_t idx;
        idx = '0;
        for (int i = 0; i < ROW_BITS; i++)
        begin
            if (v[i])
                idx = BIT_W'(i);
        end
        return idx;
    endfunction

    function automatic slot_t slot_of(row_idx_t row, bit_idx_t b);
        return SLOT_W'(int'(row) * ROW_BITS + int'(b));
    endfunction

    function automatic row_idx_t row_of(slot_t s);
        return ROW_IDX_W'(int'(s) / ROW_BITS);
    endfunction

    function automatic bit_idx_t bit_of(slot_t s);
        return BIT_W'(int'(s) % ROW_BITS);
    endfunction

endpackage

`default_nettype wire

// File: rtl/reference_number_allocator_top.sv
// Obtain passes the row read, update and done steps; a refused obtain goes straight to done;
// free adds the high-mark rescan (scan, high) after the update. The bitmap row read is registered.
// Requests are taken one at a time, only in the idle state; a stalled response holds done, but a new
// request is taken while the previous response waits in the output register.
// Reset: asynchronous, clears occupancy flags, high mark, count and handshakes.
// Top level of the reference number allocator; uses refa_pkg, refa_ctrl, refa_bitmap.
`default_nettype none

module reference_number_allocator_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  refa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output refa_pkg::rsp_t rsp
);
    import refa_pkg::*;

    bm_rd_t  bm_rd;
    bm_wr_t  bm_wr;
    row_t    bm_rdata;
    bm_sum_t bm_sum;

    refa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .bm_rd     (bm_rd),
        .bm_wr     (bm_wr),
        .bm_rdata  (bm_rdata),
        .bm_sum    (bm_sum)
    );

    refa_bitmap u_bitmap (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (bm_rd),
        .wr    (bm_wr),
        .rdata (bm_rdata),
        .sum   (bm_sum)
    );

endmodule

`default_nettype wire

// File: rtl/refa_bitmap.sv
// Occupancy bitmap: row memory with registered read, plus per-row
// nonempty and full summary flags. Depends on refa_pkg.
`default_nettype none

module refa_bitmap (
    input  logic              clk,
    input  logic              rst_n,
    input  refa_pkg::bm_rd_t  rd,
    input  refa_pkg::bm_wr_t  wr,
    output refa_pkg::row_t    rdata,
    output refa_pkg::bm_sum_t sum
);
    import refa_pkg::*;

    row_t     mem [ROWS];
    row_t     rdata_reg;
    logic     rvalid_reg;
    row_vec_t nonempty_reg;
    row_vec_t full_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.row] <= wr.data;
        if (rd.en)
            rdata_reg <= mem[rd.row];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg   <= 1'b0;
            nonempty_reg <= '0;
            full_reg     <= '0;
        end
        else
        begin
            if (rd.en)
                rvalid_reg <= nonempty_reg[rd.row];
            if (wr.en)
            begin
                nonempty_reg[wr.row] <= |wr.data;
                full_reg[wr.row]     <= &(wr.data | ~usable_mask(wr.row));
            end
        end
    end

    // a row never written since reset reads as empty
    assign rdata        = rvalid_reg ? rdata_reg : '0;
    assign sum.nonempty = nonempty_reg;
    assign sum.full     = full_reg;

endmodule

`default_nettype wire

// File: rtl/refa_ctrl.sv
// Request sequencer: free-slot search, release and high-mark rescan over the
// bitmap, owner table, counters and response register. Depends on refa_pkg.
`default_nettype none

module refa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  refa_pkg::req_t    req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output refa_pkg::rsp_t    rsp,
    output refa_pkg::bm_rd_t  bm_rd,
    output refa_pkg::bm_wr_t  bm_wr,
    input  refa_pkg::row_t    bm_rdata,
    input  refa_pkg::bm_sum_t bm_sum
);
    import refa_pkg::*;

    refa_state_t state_reg, state_next;
    req_t        op_reg, op_next;
    row_idx_t    row_reg, row_next;
    rsp_t        res_reg, res_next;
    slot_t       high_reg, high_next;
    cnt_t        live_reg, live_next;
    rsp_t        rsp_reg, rsp_next;
    logic        rsp_valid_reg, rsp_valid_next;

    logic [15:0] owner_mem [REF_SLOTS];
    logic        own_we;
    slot_t       own_addr;

    row_t     free_vec;
    bit_idx_t pick_bit;
    slot_t    pick_slot;
    slot_t    rel_slot;
    bit_idx_t rel_bit;

    function automatic rsp_t make_rsp(slot_t r, logic [1:0] st, slot_t hi, cnt_t cnt);
        rsp_t p;
        p.ref_out      = 8'(r);
        p.status       = st;
        p.highest_open = 8'(hi);
        p.open_count   = 8'(cnt);
        return p;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            high_reg      <= '0;
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            high_reg      <= high_next;
            live_reg      <= live_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        row_reg <= row_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
        if (own_we)
            owner_mem[own_addr] <= op_reg.owner_handle;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        row_next       = row_reg;
        res_next       = res_reg;
        high_next      = high_reg;
        live_next      = live_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        req_stall      = 1'b1;
        bm_rd          = '0;
        bm_wr          = '0;
        own_we         = 1'b0;
        own_addr       = '0;

        free_vec  = ~bm_rdata & usable_mask(row_reg);
        pick_bit  = lowest_bit(free_vec);
        pick_slot = slot_of(row_reg, pick_bit);
        rel_slot  = SLOT_W'(op_reg.ref_number);
        rel_bit   = bit_of(rel_slot);

        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    op_next = req;
                    if (req.action == ACT_OBTAIN)
                    begin
                        if ((32'(live_reg) + 1 < REF_SLOTS) && (~bm_sum.full != '0))
                        begin
                            row_next     = lowest_row(~bm_sum.full);
                            bm_rd.en     = 1'b1;
                            bm_rd.row    = row_next;
                            state_next   = ST_ROW;
                        end
                        else
                        begin
                            res_next   = make_rsp('0, STAT_NOREF, high_reg, live_reg);
                            state_next = ST_DONE;
                        end
                    end
                    else if (32'(req.ref_number) < REF_SLOTS)
                    begin
                        row_next   = row_of(SLOT_W'(req.ref_number));
                        bm_rd.en   = 1'b1;
                        bm_rd.row  = row_next;
                        state_next = ST_ROW;
                    end
                    else
                    begin
                        res_next   = make_rsp('0, STAT_WASFREE, high_reg, live_reg);
                        state_next = ST_DONE;
                    end
                end
            end

            ST_ROW:
            begin
                state_next = ST_UPD;
            end

            ST_UPD:
            begin
                if (op_reg.action == ACT_OBTAIN)
                begin
                    bm_wr.en   = 1'b1;
                    bm_wr.row  = row_reg;
                    bm_wr.data = bm_rdata | (row_t'(1) << pick_bit);
                    own_we     = 1'b1;
                    own_addr   = pick_slot;
                    live_next  = live_reg + cnt_t'(1);
                    high_next  = (pick_slot > high_reg) ? pick_slot : high_reg;
                    res_next   = make_rsp(pick_slot, STAT_ALLOC, high_next, live_next);
                    state_next = ST_DONE;
                end
                else if (bm_rdata[rel_bit])
                begin
                    bm_wr.en   = 1'b1;
                    bm_wr.row  = row_reg;
                    bm_wr.data = bm_rdata & ~(row_t'(1) << rel_bit);
                    if (live_reg != '0)
                        live_next = live_reg - cnt_t'(1);
                    state_next = ST_SCAN;
                end
                else
                begin
                    res_next   = make_rsp('0, STAT_WASFREE, high_reg, live_reg);
                    state_next = ST_DONE;
                end
            end

            ST_SCAN:
            begin
                if (bm_sum.nonempty != '0)
                begin
                    row_next   = highest_row(bm_sum.nonempty);
                    bm_rd.en   = 1'b1;
                    bm_rd.row  = row_next;
                    state_next = ST_HIGH;
                end
                else
                begin
                    high_next  = '0;
                    res_next   = make_rsp('0, STAT_FREED, high_next, live_reg);
                    state_next = ST_DONE;
                end
            end

            ST_HIGH:
            begin
                high_next  = slot_of(row_reg, highest_bit(bm_rdata));
                res_next   = make_rsp('0, STAT_FREED, high_next, live_reg);
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_empty_no_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && live_reg == '0) |-> (high_reg == '0))
        else $error("high mark nonzero with no open references");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start");

    a_write_in_upd: assert property (@(posedge clk) disable iff (!rst_n)
        bm_wr.en |-> (state_reg == ST_UPD))
        else $error("bitmap write outside update step");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("response raised outside done step");

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for reference_number_allocator_top: obtain/free requests
// go through a queue-fed driver; a monitor checks every response against a predictor.
// Depends on refa_pkg and the allocator RTL only.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import refa_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE      = 20;

    typedef struct {
        req_t item;
        bit   hold_for_drain;
    } pending_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    pending_req_t pending_reqs[$];
    rsp_t         expected_rsp[$];

    logic [REF_SLOTS-1:0] slot_taken = '0;
    int unsigned top_slot = 0;
    int unsigned open_refs = 0;

    int gap_left = 0;
    int stall_left = 0;
    bit send_burst = 0;
    bit recv_burst = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    reference_number_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int pick_wait(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic predict_response(input req_t r);
        rsp_t        e;
        int unsigned s;
        bit          found;
        e = '0;
        found = 0;
        if (r.action == ACT_OBTAIN)
        begin
            if (open_refs + 1 < REF_SLOTS)
            begin
                for (s = 1; s < REF_SLOTS && !found; s++)
                begin
                    if (!slot_taken[s])
                    begin
                        found = 1;
                        slot_taken[s] = 1'b1;
                        open_refs++;
                        if (top_slot < s)
                            top_slot = s;
                        e.ref_out = 8'(s);
                    end
                end
            end
            e.status = found ? STAT_ALLOC : STAT_NOREF;
        end
        else if (int'(r.ref_number) >= REF_SLOTS || !slot_taken[r.ref_number])
            e.status = STAT_WASFREE;
        else
        begin
            slot_taken[r.ref_number] = 1'b0;
            s = (top_slot >= REF_SLOTS) ? REF_SLOTS - 1 : top_slot;
            while (s > 0 && !slot_taken[s])
                s--;
            top_slot = s;
            if (open_refs > 0)
                open_refs--;
            e.status = STAT_FREED;
        end
        e.highest_open = 8'(top_slot);
        e.open_count = 8'(open_refs);
        expected_rsp.push_back(e);
    endtask

    task automatic check_response(input rsp_t got);
        rsp_t e;
        if (expected_rsp.size() == 0)
        begin
            $display("%0t: unexpected response %p", $time, got);
            mismatches++;
        end
        else
        begin
            e = expected_rsp.pop_front();
            if (got.ref_out !== e.ref_out)
            begin
                $display("%0t: ref_out expected %0d actual %0d", $time, e.ref_out, got.ref_out);
                mismatches++;
            end
            if (got.status !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
                mismatches++;
            end
            if (got.highest_open !== e.highest_open)
            begin
                $display("%0t: highest_open expected %0d actual %0d", $time,
                         e.highest_open, got.highest_open);
                mismatches++;
            end
            if (got.open_count !== e.open_count)
            begin
                $display("%0t: open_count expected %0d actual %0d", $time,
                         e.open_count, got.open_count);
                mismatches++;
            end
        end
    endtask

    task automatic add_req(input logic act, input logic [15:0] owner,
                           input logic [7:0] num, input bit drain);
        pending_req_t p;
        p.item.action = act;
        p.item.owner_handle = owner;
        p.item.ref_number = num;
        p.hold_for_drain = drain;
        pending_reqs.push_back(p);
    endtask

    task automatic add_random(input int count, input int obtain_pct, input bit drain_first);
        logic act;
        for (int i = 0; i < count; i++)
        begin
            act = ($urandom_range(0, 99) < obtain_pct) ? ACT_OBTAIN : ACT_FREE;
            add_req(act, 16'($urandom), 8'($urandom), drain_first && i == 0);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predict_response(req);
                if ($urandom_range(0, 63) == 0)
                    send_burst = !send_burst;
                gap_left = pick_wait(send_burst);
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 &&
                         (!pending_reqs[0].hold_for_drain || expected_rsp.size() == 0))
                begin
                    req <= pending_reqs[0].item;
                    req_valid <= 1'b1;
                    pending_reqs.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                check_response(rsp);
                if ($urandom_range(0, 63) == 0)
                    recv_burst = !recv_burst;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_wait(recv_burst);
                if (stall_left > 0)
                begin
                    stall_left--;
                    rsp_stall <= 1'b1;
                end
                else
                    rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout", $time);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        add_req(ACT_FREE, 16'h0000, 8'd0, 0);
        add_req(ACT_FREE, 16'hFFFF, 8'd255, 0);
        add_req(ACT_FREE, 16'h1234, 8'd1, 0);
        add_req(ACT_OBTAIN, 16'h0000, 8'hFF, 0);
        add_req(ACT_OBTAIN, 16'hFFFF, 8'h00, 0);
        add_req(ACT_OBTAIN, 16'hAAAA, 8'h55, 0);
        add_req(ACT_OBTAIN, 16'h5555, 8'hAA, 0);
        add_req(ACT_FREE, 16'h0000, 8'd2, 0);
        add_req(ACT_FREE, 16'h0000, 8'd2, 0);
        add_req(ACT_OBTAIN, 16'h8001, 8'd0, 0);
        add_req(ACT_FREE, 16'h0000, 8'd4, 0);
        add_req(ACT_FREE, 16'h0000, 8'd3, 0);
        add_req(ACT_FREE, 16'h0000, 8'd1, 0);
        add_req(ACT_FREE, 16'h0000, 8'd2, 0);
        add_req(ACT_OBTAIN, 16'h7FFE, 8'd0, 0);
        add_req(ACT_FREE, 16'hFFFF, 8'd0, 0);
        add_req(ACT_FREE, 16'h0000, 8'd255, 0);
        add_req(ACT_FREE, 16'h0000, 8'd1, 0);
        // fill the table with mostly obtains, then thin it out with mixed traffic that favours frees
        add_random(270, 96, 1);
        add_random(130, 30, 1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pending_reqs.size() > 0 || req_valid || expected_rsp.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
